// ----- src/bemp_pkg.sv -----
// ---------------------------------------------------------------------------
// bemp_pkg
// Shared types, constants and helpers for the binned event mixing pool.
// ---------------------------------------------------------------------------
`default_nettype none

package bemp_pkg;

  localparam int SLOT_DEPTH      = 16;
  localparam int CENTRALITY_BINS = 5;
  localparam int VERTEX_BINS     = 16;
  localparam int HANDLE_BITS     = 32;
  localparam int SLICE_WIDTH     = 160;
  localparam int NBINS           = CENTRALITY_BINS * VERTEX_BINS;
  localparam int HALF_RANGE      = (VERTEX_BINS / 2) * SLICE_WIDTH;

  // Reciprocal of the slice width scaled by 2^20; exact for offsets up to 2560
  localparam int SLICE_RECIP     = 6554;
  localparam int SLICE_SHIFT     = 20;

  localparam int SLOT_W  = $clog2(SLOT_DEPTH);
  localparam int CNT_W   = $clog2(SLOT_DEPTH + 1);
  localparam int BIN_W   = $clog2(NBINS);
  localparam int ADDR_W  = $clog2(NBINS * SLOT_DEPTH);
  localparam int SLICE_W = $clog2(VERTEX_BINS);
  localparam int TOT_W   = 11;
  localparam int Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD_RAND = 3'd0,
    OP_ADD_FIFO = 3'd1,
    OP_ADD_RES  = 3'd2,
    OP_SAMPLE   = 3'd3,
    OP_SAMPLE_ALL = 3'd4,
    OP_QUERY    = 3'd5,
    OP_NONE6    = 3'd6,
    OP_NONE7    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DISCARD = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t                    op;
    logic                   bad;
    logic [BIN_W-1:0]       bin;
    logic [HANDLE_BITS-1:0] handle;
    logic [31:0]            rnd;
  } cmd_t;

  // Per-bin bookkeeping kept in one memory word
  typedef struct packed {
    logic [CNT_W-1:0]  fill;
    logic [SLOT_W-1:0] oldest;
    logic [31:0]       seen;
  } bin_state_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOOK, BK_MOD, BK_MUL, BK_WRITE, BK_READ, BK_EMIT, BK_CLEAR
  } bk_state_t;

endpackage

`default_nettype wire

// ----- src/bemp_front.sv -----
// ---------------------------------------------------------------------------
// bemp_front
// Accepts input items, computes the bin index and range flag, and queues
// the classified command for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module bemp_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [2:0]            op_i,
  input  wire logic [2:0]            cen_i,
  input  wire logic signed [11:0]    z_i,
  input  wire logic [bemp_pkg::HANDLE_BITS-1:0] handle_i,
  input  wire logic [31:0]           rnd_i,
  output logic                       q_valid,
  input  wire logic                  q_pop,
  output bemp_pkg::cmd_t             q_cmd
);
  import bemp_pkg::*;

  localparam int QP_W = $clog2(Q_DEPTH);

  cmd_t              q_mem_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]     cnt_r;
  logic signed [12:0] zs;
  logic [12:0]       zoff;
  logic [25:0]       slice_p;
  logic [SLICE_W:0]  slice;
  logic [SLICE_W-1:0] slice_c;
  logic              bad;
  cmd_t              cmd;
  logic              push;

  // Classify: slice = (z + half) / 160, by reciprocal multiply and shift
  always_comb begin
    zs   = 13'(z_i);
    bad  = (zs < -13'(HALF_RANGE)) || (zs > 13'(HALF_RANGE)) ||
           (cen_i >= 3'(CENTRALITY_BINS));
    zoff = 13'(zs + 13'(HALF_RANGE));
    slice_p = 26'(zoff) * 26'(SLICE_RECIP);
    slice = slice_p[SLICE_SHIFT +: SLICE_W+1];
    slice_c = (slice >= (SLICE_W+1)'(VERTEX_BINS)) ? SLICE_W'(VERTEX_BINS - 1)
                                                   : slice[SLICE_W-1:0];
    cmd.op     = op_t'(op_i);
    cmd.bad    = bad;
    cmd.bin    = BIN_W'(cen_i) * BIN_W'(VERTEX_BINS) + BIN_W'(slice_c);
    cmd.handle = handle_i;
    cmd.rnd    = rnd_i;
  end

  assign in_tready = (cnt_r < (QP_W+1)'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = q_mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cmd;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QP_W+1)'(push) - (QP_W+1)'(q_pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/bemp_divu.sv -----
// ---------------------------------------------------------------------------
// bemp_divu
// Bit-serial 32 by 5 bit remainder unit, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bemp_divu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [bemp_pkg::CNT_W-1:0] divisor,
  output logic             done,
  output logic [bemp_pkg::CNT_W-1:0] rem
);
  import bemp_pkg::*;

  logic [31:0]      dvd_r;
  logic [CNT_W:0]   rem_r;
  logic [CNT_W-1:0] dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [CNT_W:0]   trial;

  assign trial = {rem_r[CNT_W-1:0], dvd_r[31]};
  assign done  = busy_r && (cnt_r == 6'd0);
  assign rem   = rem_r[CNT_W-1:0];

  // Shift one dividend bit in per cycle, subtract when it fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && cnt_r != 6'd0) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= (trial >= {1'b0, dvs_r}) ? trial - {1'b0, dvs_r} : trial;
    end
  end

endmodule

`default_nettype wire

// ----- src/bemp_back.sv -----
// ---------------------------------------------------------------------------
// bemp_back
// Executes queued commands against the bin tables and handle memory and
// drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bemp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [4:0]          slot_limit,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire bemp_pkg::cmd_t      q_cmd,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [bemp_pkg::HANDLE_BITS-1:0] handle_o,
  output logic [bemp_pkg::CNT_W-1:0]       count_o,
  output logic [bemp_pkg::TOT_W-1:0]       total_o,
  output bemp_pkg::status_t        status_o,
  output logic                     last_o
);
  import bemp_pkg::*;

  // Bin tables: one memory word per bin, cleared by a pass after reset
  bin_state_t        bin_mem [NBINS];
  bin_state_t        bin_rd_r;
  bin_state_t        bin_wd;
  logic [BIN_W-1:0]  bin_wa;
  logic              bin_we;
  logic [BIN_W-1:0]  clr_r;
  logic [TOT_W-1:0]  total_r;

  // Handle memory, undefined until written
  logic [HANDLE_BITS-1:0] mem [NBINS*SLOT_DEPTH];
  logic [HANDLE_BITS-1:0] rd_data_r;

  bk_state_t state_r, state_nxt;
  cmd_t      cmd_r;
  logic [CNT_W-1:0]  lim_r;
  logic [SLOT_W-1:0] k_r, slot_r;
  logic [31:0]       seen_v_r;
  logic [63:0]       prod_r;
  logic              keep_r;

  logic [CNT_W-1:0]  cnt_c;
  logic [SLOT_W-1:0] old_c;
  logic [31:0]       seen_v;
  logic              keep_c;
  logic              is_add;

  logic              out_valid_r;
  logic [HANDLE_BITS-1:0] ho_r;
  logic [CNT_W-1:0]  co_r;
  logic [TOT_W-1:0]  to_r;
  status_t           so_r;
  logic              lo_r;

  logic              div_start, div_done;
  logic [31:0]       div_dvd;
  logic [CNT_W-1:0]  div_dvs, div_rem;

  logic [CNT_W-1:0]  lim_eff;
  logic              out_free;
  logic [CNT_W:0]    rd_idx;
  logic [CNT_W-1:0]  rd_mod;

  logic              do_emit, do_write, do_fill;
  logic [HANDLE_BITS-1:0] e_h;
  logic [CNT_W-1:0]  e_c;
  status_t           e_s;
  logic              e_l;
  logic [SLOT_W-1:0] w_slot;

  assign lim_eff  = (slot_limit == 5'd0) ? CNT_W'(1) :
                    (slot_limit > 5'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH) : CNT_W'(slot_limit);
  assign out_free = !out_valid_r || out_tready;

  // Bin snapshot fields, held from the pop until the next pop
  assign cnt_c  = bin_rd_r.fill;
  assign old_c  = (CNT_W'(bin_rd_r.oldest) >= bin_rd_r.fill) ? '0 : bin_rd_r.oldest;
  assign seen_v = (cmd_r.op == OP_ADD_RES && bin_rd_r.seen != 32'hFFFF_FFFF)
                  ? bin_rd_r.seen + 32'd1 : bin_rd_r.seen;
  assign keep_c = (prod_r[63:32] < 32'(lim_r));
  assign is_add = (cmd_r.op == OP_ADD_RAND) || (cmd_r.op == OP_ADD_FIFO) ||
                  (cmd_r.op == OP_ADD_RES);

  // Sample-all read index: (old + k) mod cnt, with both below cnt
  assign rd_idx = (CNT_W+1)'(old_c) + (CNT_W+1)'(k_r);
  assign rd_mod = (rd_idx >= (CNT_W+1)'(cnt_c)) ? CNT_W'(rd_idx - (CNT_W+1)'(cnt_c))
                                               : CNT_W'(rd_idx);

  bemp_divu u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .rem(div_rem)
  );

  assign div_dvd = cmd_r.rnd;
  assign div_dvs = (cmd_r.op == OP_SAMPLE) ? cnt_c : lim_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    do_emit   = 1'b0;
    do_write  = 1'b0;
    do_fill   = 1'b0;
    w_slot    = slot_r;
    e_h = '0; e_c = cnt_c; e_s = ST_OK; e_l = 1'b1;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_r == BIN_W'(NBINS - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = BK_LOOK;
        end
      end
      BK_LOOK: begin
        if (cmd_r.bad) begin
          e_c = '0; e_s = ST_RANGE;
          if (out_free) begin do_emit = 1'b1; state_nxt = BK_IDLE; end
        end else if (is_add) begin
          if (cnt_c < lim_r) begin
            w_slot = cnt_c[SLOT_W-1:0];
            do_write = 1'b1; do_fill = 1'b1;
            state_nxt = BK_EMIT;
          end else if (cmd_r.op == OP_ADD_RAND) begin
            div_start = 1'b1; state_nxt = BK_MOD;
          end else if (cmd_r.op == OP_ADD_FIFO) begin
            w_slot = old_c;
            do_write = 1'b1;
            state_nxt = BK_EMIT;
          end else begin
            state_nxt = BK_MUL;
          end
        end else if (cmd_r.op == OP_SAMPLE || cmd_r.op == OP_SAMPLE_ALL) begin
          if (cnt_c == '0) begin
            e_s = ST_EMPTY;
            if (out_free) begin do_emit = 1'b1; state_nxt = BK_IDLE; end
          end else if (cmd_r.op == OP_SAMPLE) begin
            div_start = 1'b1; state_nxt = BK_MOD;
          end else begin
            state_nxt = BK_READ;
          end
        end else begin
          if (out_free) begin do_emit = 1'b1; state_nxt = BK_IDLE; end
        end
      end
      BK_MOD: begin
        if (div_done) begin
          if (cmd_r.op == OP_SAMPLE) begin
            state_nxt = BK_READ;
          end else begin
            w_slot = div_rem[SLOT_W-1:0];
            do_write = 1'b1;
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_MUL: begin
        state_nxt = BK_WRITE;
      end
      BK_WRITE: begin
        if (keep_c) begin
          w_slot = prod_r[32 +: SLOT_W];
          do_write = 1'b1;
        end
        state_nxt = BK_EMIT;
      end
      BK_READ: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (cmd_r.op == OP_SAMPLE || cmd_r.op == OP_SAMPLE_ALL) begin
          e_h = rd_data_r;
          e_l = (cmd_r.op == OP_SAMPLE) || (CNT_W'(k_r) + 1'b1 == cnt_c);
          if (out_free) begin
            do_emit = 1'b1;
            state_nxt = e_l ? BK_IDLE : BK_READ;
          end
        end else begin
          e_c = (cnt_c < lim_r) ? cnt_c + CNT_W'(1) : cnt_c;
          e_s = (cmd_r.op == OP_ADD_RES && cnt_c >= lim_r && !keep_r) ? ST_DISCARD
                                                                      : ST_OK;
          if (out_free) begin do_emit = 1'b1; state_nxt = BK_IDLE; end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_CLEAR;
    else state_r <= state_nxt;
  end

  // Step the clearing pass over the bin tables
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == BK_CLEAR) clr_r <= clr_r + BIN_W'(1);
  end

  // Latch command and working values
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_cmd;
      lim_r  <= lim_eff;
      k_r    <= '0;
      keep_r <= 1'b1;
    end
    if (state_r == BK_LOOK) seen_v_r <= seen_v;
    if (state_r == BK_MUL) prod_r <= 64'(cmd_r.rnd) * 64'(seen_v_r);
    if (state_r == BK_WRITE) keep_r <= keep_c;
    if (state_r == BK_MOD && div_done) slot_r <= div_rem[SLOT_W-1:0];
    if (state_r == BK_EMIT && do_emit && !e_l) k_r <= k_r + 1'b1;
  end

  // Handle memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) mem[{cmd_r.bin, w_slot}] <= cmd_r.handle;
    if (state_nxt == BK_READ || (state_r == BK_MOD && state_nxt == BK_READ))
      rd_data_r <= mem[{cmd_r.bin, (cmd_r.op == OP_SAMPLE) ? div_rem[SLOT_W-1:0]
                        : ((state_r == BK_EMIT) ? SLOT_W'(rd_mod + 1'b1 == cnt_c ?
                           '0 : rd_mod + 1'b1) : SLOT_W'(rd_mod))}];
  end

  // Bin table write: clear pass, or the update of an add
  always_comb begin
    bin_wd = bin_rd_r;
    bin_we = 1'b0;
    bin_wa = cmd_r.bin;
    if (state_r == BK_CLEAR) begin
      bin_we = 1'b1;
      bin_wa = clr_r;
      bin_wd = '0;
    end else if (state_r == BK_LOOK && !cmd_r.bad && is_add) begin
      bin_we = 1'b1;
      bin_wd.seen = seen_v;
      if (do_fill) begin
        bin_wd.fill = cnt_c + CNT_W'(1);
      end else if (do_write && cmd_r.op == OP_ADD_FIFO) begin
        bin_wd.oldest = (CNT_W'(old_c) + 1'b1 == cnt_c) ? '0 : old_c + SLOT_W'(1);
      end
    end
  end

  // Bin tables: one write port, one registered read port at the pop
  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (q_pop) bin_rd_r <= bin_mem[q_cmd.bin];
  end

  // Count the handles held across all bins
  always_ff @(posedge clk) begin
    if (!rst_n) total_r <= '0;
    else if (do_fill) total_r <= total_r + TOT_W'(1);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (do_emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      ho_r <= e_h;
      co_r <= e_c;
      to_r <= total_r;
      so_r <= e_s;
      lo_r <= e_l;
    end
  end

  assign out_tvalid = out_valid_r;
  assign handle_o   = ho_r;
  assign count_o    = co_r;
  assign total_o    = to_r;
  assign status_o   = so_r;
  assign last_o     = lo_r;

endmodule

`default_nettype wire

// ----- src/binned_event_mixing_pool.sv -----
// ---------------------------------------------------------------------------
// binned_event_mixing_pool
// Event handle pool binned by centrality and vertex z with replacement.
// ---------------------------------------------------------------------------
// Items enter a two-deep command queue after bin classification and are run
// one at a time by the back end. After reset the back end clears its bin
// tables and takes nothing until the pass ends; the queue still accepts two
// items. A query, out-of-range or empty-bin sample is answered from the bin
// lookup; an append or FIFO add writes its handle at the lookup; a reservoir
// add multiplies, then compares and writes; a random replace and a single
// sample wait on the bit-serial remainder unit; a sample-all returns its
// handles one at a time through the single read port of the handle memory.
// A stalled result holds the back end for as long as out_tready stays low.
`default_nettype none

module binned_event_mixing_pool (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[2:0], centrality[5:3], vertex_z[17:6], event_handle[49:18],
  // random_value[81:50], zero fill to 88
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // handle_out[31:0], bin_count[36:32], total_stored[47:37], status[49:48], fill to 56
  output logic [55:0]      out_tdata,
  output logic             out_tlast
);
  import bemp_pkg::*;

  logic [4:0] slot_limit_r;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;
  logic [HANDLE_BITS-1:0] h_o;
  logic [CNT_W-1:0] c_o;
  logic [TOT_W-1:0] t_o;
  status_t    s_o;

  // Hold the slot limit register
  always_ff @(posedge clk) begin
    if (!rst_n) slot_limit_r <= 5'd16;
    else if (cfg_we) slot_limit_r <= cfg_wdata;
  end

  bemp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .op_i(in_tdata[2:0]), .cen_i(in_tdata[5:3]), .z_i(in_tdata[17:6]),
    .handle_i(in_tdata[49:18]), .rnd_i(in_tdata[81:50]),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  bemp_back u_back (
    .clk(clk), .rst_n(rst_n), .slot_limit(slot_limit_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .handle_o(h_o), .count_o(c_o), .total_o(t_o), .status_o(s_o), .last_o(out_tlast)
  );

  assign out_tdata = {6'd0, s_o, t_o, c_o, h_o};

endmodule

`default_nettype wire

// ----- src/bemp_checker.sv -----
// ---------------------------------------------------------------------------
// bemp_checker
// Port-level checks for the binned event mixing pool.
// ---------------------------------------------------------------------------
`default_nettype none

module bemp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Error results carry no handle and are final
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[49:48] == 2'd3 || out_tdata[49:48] == 2'd2)
    |-> out_tlast && out_tdata[31:0] == 32'd0)
    else $error("error result malformed");

  // Bin count stays within slot depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:32] <= 5'd16)
    else $error("bin count too large");

endmodule

bind binned_event_mixing_pool bemp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);

`default_nettype wire
